// File: rtl/core/qsl_pkg.sv
// Package for the quicksort unit: sizes, sequencer states and the IEEE less-than.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qsl_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int STACK_DEPTH = 7;
    localparam int IDX_W       = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_POP,
        ST_RANGE,
        ST_PIV_RD,
        ST_PIV_WT,
        ST_SCAN_RD,
        ST_SCAN_WT,
        ST_SCAN_CMP,
        ST_SWAP_RB,
        ST_SWAP_WR,
        ST_FIN_RD,
        ST_FIN_WT,
        ST_FIN_WR,
        ST_SPLIT,
        ST_INS_K,
        ST_INS_RD,
        ST_INS_WT,
        ST_INS_CMP,
        ST_INS_PUT,
        ST_OUT_RD,
        ST_OUT_WT,
        ST_OUT_HOLD
    } state_t;

    // memory request from the sequencer to the element store
    typedef struct packed {
        logic        we;
        idx_t        waddr;
        logic [63:0] wdata;
        idx_t        raddr;
    } mem_req_t;

    // IEEE less-than on bit patterns
    function automatic logic fp_less(input logic [63:0] a, input logic [63:0] b);
        logic [62:0] ma;
        logic [62:0] mb;
        logic        r;
        ma = a[62:0];
        mb = b[62:0];
        if (ma > 63'h7FF0000000000000 || mb > 63'h7FF0000000000000)
            r = 1'b0;
        else if (ma == '0 && mb == '0)
            r = 1'b0;
        else if (a[63] != b[63])
            r = a[63];
        else if (!a[63])
            r = ma < mb;
        else
            r = ma > mb;
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/qsl_store.sv
// Element store: one write port, one registered read port.
// Depends on qsl_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qsl_store
    import qsl_pkg::*;
(
    input  wire logic        clk,
    input  wire mem_req_t    req,
    output      logic [63:0] rdata
);

    logic [63:0] mem [MAX_ITEMS];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
            mem[req.waddr] <= req.wdata;
        rdata <= mem[req.raddr];
    end

endmodule
`default_nettype wire

// File: rtl/core/quicksort_lomuto_double_unit.sv
// Quicksort unit top level: load sequencer, partition engine and output stage.
// Depends on qsl_pkg and qsl_store.
//
// Usage:
//   s_axis: tdata = value[63:0], tlast = last. One element per transfer; the
//   element marked last starts the sort. Elements beyond 64 are discarded and
//   flag the set as dropped.
//   m_axis: tdata = sorted_value[63:0], tuser = dropped, tlast = final_res.
//   Results leave in ascending order, one transfer per element.
// Timing:
//   Loading accepts one element per cycle. Sorting runs on one shared
//   comparator and a store with one write port and one registered read port:
//   each scan step reads and compares an element, and each swap writes two
//   entries; N log N on average. Emission reads, registers and holds each element.
//   s_axis_tready is low from the last element until emission ends.
// Reset: asynchronous, active low; clears the count, stack pointer, flag and
//   sequencer. Store contents are not cleared.
// Stall: a result stays on m_axis until taken; the sequencer waits.
`timescale 1ns / 1ps
`default_nettype none
module quicksort_lomuto_double_unit
    import qsl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // value[63:0]
    input  wire logic        s_axis_tlast,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [63:0] m_axis_tdata,   // sorted_value[63:0]
    output      logic        m_axis_tuser,   // dropped
    output      logic        m_axis_tlast
);

    state_t state_reg, state_next;
    cnt_t   count_reg, count_next;
    logic   ovf_reg, ovf_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    idx_t   stk_lo_reg [STACK_DEPTH];
    idx_t   stk_hi_reg [STACK_DEPTH];
    idx_t   lo_reg, lo_next, hi_reg, hi_next;
    idx_t   bound_reg, bound_next, scan_reg, scan_next;
    logic [63:0] pivot_reg, pivot_next, tmp_reg, tmp_next;
    idx_t   k_reg, k_next, m_reg, m_next;
    logic   push_en;
    idx_t   push_lo, push_hi;
    mem_req_t req;
    logic [63:0] rdata;
    logic [63:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    idx_t        n_m1;
    logic [2*IDX_W:0] stk_save_reg, stk_save_next;
    logic [63:0] cmp_b;
    logic        cmp_lt;

    qsl_store u_store (.clk(clk), .req(req), .rdata(rdata));

    assign n_m1 = IDX_W'(count_reg - 1'b1);

    // shared comparator: scan against pivot, insertion against store entry
    assign cmp_b  = (state_reg == ST_INS_CMP) ? rdata : pivot_reg;
    assign cmp_lt = fp_less(tmp_reg, cmp_b);

    // split arithmetic
    logic [IDX_W:0] left_len, right_len;
    idx_t sl, sh, bl, bh;
    logic sm_ok, bg_ok;
    always_comb
    begin
        left_len  = {1'b0, bound_reg} - {1'b0, lo_reg};
        right_len = {1'b0, hi_reg} - {1'b0, bound_reg};
        if (left_len > right_len)
        begin
            sl = bound_reg + 1'b1; sh = hi_reg;
            bl = lo_reg;           bh = bound_reg - 1'b1;
            sm_ok = bound_reg < hi_reg;
            bg_ok = bound_reg > lo_reg + 1'b1 && bound_reg != lo_reg;
        end
        else
        begin
            sl = lo_reg;           sh = bound_reg - 1'b1;
            bl = bound_reg + 1'b1; bh = hi_reg;
            sm_ok = bound_reg > lo_reg;
            bg_ok = {1'b0, hi_reg} > {1'b0, bound_reg} + 2'd1;
        end
    end

    // next state and datapath
    always_comb
    begin
        state_next = state_reg; count_next = count_reg; ovf_next = ovf_reg;
        sp_next = sp_reg; lo_next = lo_reg; hi_next = hi_reg;
        bound_next = bound_reg; scan_next = scan_reg; pivot_next = pivot_reg;
        tmp_next = tmp_reg; k_next = k_reg; m_next = m_reg;
        stk_save_next = stk_save_reg;
        push_en = 1'b0; push_lo = bl; push_hi = bh;
        out_data_next = out_data_reg; out_last_next = out_last_reg;
        req = '{we: 1'b0, waddr: '0, wdata: s_axis_tdata, raddr: '0};
        unique case (state_reg)
            ST_LOAD:
            begin
                req.waddr = IDX_W'(count_reg);
                if (s_axis_tvalid)
                begin
                    if (count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        req.we = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                        ovf_next = 1'b1;
                    if (s_axis_tlast)
                    begin
                        if ((count_next) >= CNT_W'(2))
                        begin
                            push_en = 1'b1; push_lo = '0;
                            push_hi = IDX_W'(count_next - 1'b1);
                            state_next = ST_POP;
                        end
                        else if (count_next == CNT_W'(1))
                        begin
                            k_next = '0;
                            state_next = ST_OUT_RD;
                        end
                        else
                        begin
                            ovf_next = 1'b0;
                        end
                    end
                end
            end
            ST_POP:
                if (sp_reg == '0)
                begin
                    k_next = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    sp_next = sp_reg - 1'b1;
                    lo_next = stk_lo_reg[sp_next];
                    hi_next = stk_hi_reg[sp_next];
                    state_next = ST_RANGE;
                end
            ST_RANGE:
                state_next = (lo_reg < hi_reg) ? ST_PIV_RD : ST_POP;
            ST_PIV_RD:
            begin
                req.raddr = hi_reg;
                bound_next = lo_reg; scan_next = lo_reg;
                state_next = ST_PIV_WT;
            end
            ST_PIV_WT:
            begin
                pivot_next = rdata;
                state_next = ST_SCAN_RD;
            end
            ST_SCAN_RD:
            begin
                req.raddr = scan_reg;
                state_next = (scan_reg < hi_reg) ? ST_SCAN_WT : ST_FIN_RD;
            end
            ST_SCAN_WT:
            begin
                req.raddr = bound_reg;
                tmp_next = rdata;
                state_next = ST_SCAN_CMP;
            end
            ST_SCAN_CMP:
            begin
                // keep store[bound] on the read port for the swap
                req.raddr = bound_reg;
                if (cmp_lt)
                    state_next = ST_SWAP_RB;
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SWAP_RB:
            begin
                // rdata holds store[bound]; put scan value at bound
                req.we = 1'b1; req.waddr = bound_reg; req.wdata = tmp_reg;
                tmp_next = rdata;
                state_next = ST_SWAP_WR;
            end
            ST_SWAP_WR:
            begin
                req.we = 1'b1; req.waddr = scan_reg; req.wdata = tmp_reg;
                bound_next = bound_reg + 1'b1;
                scan_next = scan_reg + 1'b1;
                state_next = ST_SCAN_RD;
            end
            ST_FIN_RD:
            begin
                req.raddr = bound_reg;
                state_next = ST_FIN_WT;
            end
            ST_FIN_WT:
            begin
                req.we = 1'b1; req.waddr = bound_reg; req.wdata = pivot_reg;
                tmp_next = rdata;
                state_next = ST_FIN_WR;
            end
            ST_FIN_WR:
            begin
                req.we = 1'b1; req.waddr = hi_reg; req.wdata = tmp_reg;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                lo_next = sl; hi_next = sh;
                if (!sm_ok)
                begin
                    lo_next = '1; hi_next = '0;
                end
                state_next = ST_RANGE;
                if (bg_ok)
                begin
                    if (sp_reg < SP_W'(STACK_DEPTH))
                        push_en = 1'b1;
                    else
                    begin
                        // stack full: insertion sort of the larger side
                        push_lo = sl; push_hi = sh;
                        push_en = 1'b0;
                        lo_next = bl; hi_next = bh;
                        k_next = bl + 1'b1;
                        stk_save_next = {sm_ok, sl, sh};
                        state_next = ST_INS_K;
                    end
                end
            end
            ST_INS_K:
            begin
                req.raddr = k_reg;
                m_next = k_reg;
                state_next = ST_INS_WT;
            end
            ST_INS_WT:
            begin
                tmp_next = rdata;
                state_next = ST_INS_RD;
            end
            ST_INS_RD:
            begin
                req.raddr = m_reg - 1'b1;
                state_next = (m_reg > lo_reg) ? ST_INS_CMP : ST_INS_PUT;
            end
            ST_INS_CMP:
                // rdata is store[m-1]
                if (cmp_lt)
                begin
                    req.we = 1'b1; req.waddr = m_reg; req.wdata = rdata;
                    m_next = m_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
                else
                    state_next = ST_INS_PUT;
            ST_INS_PUT:
            begin
                req.we = 1'b1; req.waddr = m_reg; req.wdata = tmp_reg;
                if (k_reg == hi_reg)
                begin
                    lo_next = stk_save_reg[2*IDX_W-1:IDX_W];
                    hi_next = stk_save_reg[IDX_W-1:0];
                    if (!stk_save_reg[2*IDX_W])
                    begin
                        lo_next = '1; hi_next = '0;
                    end
                    state_next = ST_RANGE;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_INS_K;
                end
            end
            ST_OUT_RD:
            begin
                req.raddr = k_reg;
                state_next = ST_OUT_WT;
            end
            ST_OUT_WT:
            begin
                out_data_next = rdata;
                out_last_next = (k_reg == n_m1);
                state_next = ST_OUT_HOLD;
            end
            ST_OUT_HOLD:
                if (m_axis_tready)
                begin
                    if (out_last_reg)
                    begin
                        count_next = '0; ovf_next = 1'b0; sp_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = ST_OUT_RD;
                    end
                end
            default: state_next = ST_LOAD;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            sp_reg    <= push_en ? sp_next + 1'b1 : sp_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next; hi_reg <= hi_next;
        bound_reg <= bound_next; scan_reg <= scan_next;
        pivot_reg <= pivot_next; tmp_reg <= tmp_next;
        k_reg <= k_next; m_reg <= m_next;
        stk_save_reg <= stk_save_next;
        out_data_reg <= out_data_next; out_last_reg <= out_last_next;
    end

    // range stack writes
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                if (sp_next == SP_W'(i))
                begin
                    stk_lo_reg[i] <= push_lo;
                    stk_hi_reg[i] <= push_hi;
                end
            end
        end
    end

    assign s_axis_tready = (state_reg == ST_LOAD);
    assign m_axis_tvalid = (state_reg == ST_OUT_HOLD);
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = ovf_reg;

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input and output active together");
    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("range stack overrun");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("element count overrun");
    a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> count_reg == '0 && !ovf_reg)
        else $error("set not cleared after emission");
`endif

endmodule
`default_nettype wire

// File: dv/quicksort_lomuto_double_checker.sv
// Checker for the quicksort unit: watches both stream channels, predicts the sorted
// output of each set and compares every result transfer. Depends on qsl_pkg.
`timescale 1ns / 1ps
module quicksort_lomuto_double_checker
    import qsl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          error_count,
    output int          pending_count
);

    typedef struct packed {
        logic [63:0] value;
        logic        final_res;
        logic        dropped;
    } sorted_item_t;

    logic [63:0]  set_store [MAX_ITEMS];
    int           set_count;
    logic         set_overflow;
    logic [11:0]  range_stk [STACK_DEPTH];
    int           range_sp;
    sorted_item_t sorted_queue[$];

    assign pending_count = sorted_queue.size();

    // IEEE less-than on raw bit patterns
    function automatic bit ieee_lt(logic [63:0] a, logic [63:0] b);
        logic [62:0] ma;
        logic [62:0] mb;
        ma = a[62:0];
        mb = b[62:0];
        if (ma > 63'h7FF0000000000000 || mb > 63'h7FF0000000000000) return 0;
        if (ma == 0 && mb == 0) return 0;
        if (a[63] != b[63]) return a[63];
        if (!a[63]) return ma < mb;
        return ma > mb;
    endfunction

    function automatic void swap_entries(int x, int y);
        logic [63:0] t;
        t = set_store[x];
        set_store[x] = set_store[y];
        set_store[y] = t;
    endfunction

    function automatic int partition_range(int lo, int hi);
        logic [63:0] piv;
        int          b;
        piv = set_store[hi];
        b = lo;
        for (int s = lo; s < hi; s++)
            if (ieee_lt(set_store[s], piv))
            begin
                swap_entries(b, s);
                b++;
            end
        swap_entries(b, hi);
        return b;
    endfunction

    function automatic void insertion_finish(int lo, int hi);
        logic [63:0] v;
        int          m;
        for (int k = lo + 1; k <= hi; k++)
        begin
            v = set_store[k];
            m = k;
            while (m > lo && ieee_lt(v, set_store[m-1]))
            begin
                set_store[m] = set_store[m-1];
                m--;
            end
            set_store[m] = v;
        end
    endfunction

    // quicksort with explicit range stack, smaller side first
    function automatic void sort_set(int n);
        int lo, hi, p, sl, sh, bl, bh;
        range_sp = 0;
        if (n < 2) return;
        range_stk[0] = {6'(0), 6'(n - 1)};
        range_sp = 1;
        while (range_sp > 0)
        begin
            range_sp--;
            lo = range_stk[range_sp][11:6];
            hi = range_stk[range_sp][5:0];
            while (lo < hi)
            begin
                p = partition_range(lo, hi);
                sl = lo; sh = p - 1; bl = p + 1; bh = hi;
                if (p - lo > hi - p)
                begin
                    sl = p + 1; sh = hi; bl = lo; bh = p - 1;
                end
                if (bh > bl)
                begin
                    if (range_sp < STACK_DEPTH)
                    begin
                        range_stk[range_sp] = {6'(bl), 6'(bh)};
                        range_sp++;
                    end
                    else
                        insertion_finish(bl, bh);
                end
                lo = sl;
                hi = sh;
            end
        end
    endfunction

    // input side: collect set, predict on last
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_count    <= 0;
            set_overflow <= 0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            int          n;
            logic        ovf;
            n = set_count;
            ovf = set_overflow;
            if (n < MAX_ITEMS)
            begin
                set_store[n] = s_axis_tdata;
                n++;
            end
            else
                ovf = 1;
            if (s_axis_tlast)
            begin
                sort_set(n);
                for (int k = 0; k < n; k++)
                    sorted_queue.insert(sorted_queue.size(),
                                        '{set_store[k], k == n - 1, ovf});
                n = 0;
                ovf = 0;
            end
            set_count    <= n;
            set_overflow <= ovf;
        end
    end

    // output side: compare with oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            error_count <= 0;
        else if (m_axis_tvalid && m_axis_tready)
        begin
            sorted_item_t exp_item;
            if (sorted_queue.size() == 0)
            begin
                if (error_count < 10)
                    $display("unexpected result: value=%h last=%b dropped=%b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
                error_count <= error_count + 1;
            end
            else
            begin
                exp_item = sorted_queue.pop_front();
                if (exp_item.value !== m_axis_tdata || exp_item.final_res !== m_axis_tlast
                    || exp_item.dropped !== m_axis_tuser)
                begin
                    if (error_count < 10)
                        $display("mismatch: exp value=%h last=%b dropped=%b, got %h %b %b",
                                 exp_item.value, exp_item.final_res, exp_item.dropped,
                                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
                    error_count <= error_count + 1;
                end
            end
        end
    end

endmodule

// File: dv/quicksort_lomuto_double_unit_tb.sv
// Testbench top for the quicksort unit: drives sets of doubles with random gaps and
// stalls, and gives the verdict. Depends on qsl_pkg, the unit and the checker.
`timescale 1ns / 1ps
module quicksort_lomuto_double_unit_tb;
    import qsl_pkg::*;

    localparam longint CYCLE_LIMIT = 3000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    int          error_count;
    int          pending_count;
    longint      cycle_count;
    bit          stall_quiet;

    quicksort_lomuto_double_unit i_dut (.*);

    quicksort_lomuto_double_checker i_checker (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // receiver stalls
    initial
    begin
        int g;
        m_axis_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if (stall_quiet)
                g = 0;
            else
                g = gap_len();
            if (g == 0)
                m_axis_tready <= 1;
            else
            begin
                m_axis_tready <= 0;
                repeat (g) @(posedge clk);
                m_axis_tready <= 1;
            end
            @(posedge clk);
        end
    end

    // interesting double patterns: zeros, infinities, NaNs, subnormals, mid-range normals
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = 64'h0000000000000000;
            1: v = 64'h8000000000000000;
            2: v = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 11'h7FF, 52'h0};
            3: v = {1'($urandom), 11'h7FF, 20'($urandom) | 20'h1, 32'($urandom)};
            4: v = {1'($urandom), 11'h000, 20'($urandom), 32'($urandom)};
            5: v = {1'($urandom), 11'(10'($urandom) + 11'h200), 20'($urandom), 32'h0};
            default: v = {32'($urandom), 32'($urandom)};
        endcase
        return v;
    endfunction

    task automatic send(logic [63:0] v, logic last);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_axis_tvalid <= 0;
            repeat (g) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_set(int n);
        for (int k = 0; k < n; k++)
            send(pick_value(), k == n - 1);
    endtask

    task automatic send_sorted_set(int n, bit down);
        logic [63:0] v;
        for (int k = 0; k < n; k++)
        begin
            v = down ? 64'h4100000000000000 - 64'(k) * 64'h0010000000000000
                     : 64'hC100000000000000 - 64'(k) * 64'h0010000000000000;
            send(v, k == n - 1);
        end
    endtask

    initial
    begin
        int sent;
        int n;
        cycle_count   = 0;
        stall_quiet   = 0;
        rst_n         = 0;
        s_axis_tvalid = 0;
        s_axis_tdata  = 0;
        s_axis_tlast  = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: single item, pair, extremes with zeros and NaNs
        send(64'hFFFFFFFFFFFFFFFF, 1);
        send(64'h0000000000000000, 0);
        send(64'h8000000000000000, 1);
        send(64'h7FF0000000000000, 0);
        send(64'hFFF0000000000000, 0);
        send(64'h7FF8000000000000, 0);
        send(64'h0000000000000001, 0);
        send(64'h7FEFFFFFFFFFFFFF, 0);
        send(64'hFFEFFFFFFFFFFFFF, 0);
        send(64'h8000000000000001, 1);
        // presorted and reversed runs
        send_sorted_set(6, 0);
        send_sorted_set(6, 1);
        sent = 22;

        // overflowing set: more than capacity, then a set that fills capacity exactly
        stall_quiet = 1;
        send_set(MAX_ITEMS + 3);
        stall_quiet = 0;
        send_sorted_set(MAX_ITEMS, 1);
        sent += 2 * MAX_ITEMS + 3;

        // random sets, mostly small
        while (sent < 350)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_ITEMS)
                                            : $urandom_range(1, 12);
            stall_quiet = ($urandom_range(0, 4) == 0);
            send_set(n);
            sent += n;
        end
        s_axis_tvalid <= 0;
        s_axis_tlast  <= 0;

        // let the checker take in the last transfer before waiting
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: quicksort_lomuto_double_unit.f
rtl/core/qsl_pkg.sv
rtl/core/qsl_store.sv
rtl/core/quicksort_lomuto_double_unit.sv
dv/quicksort_lomuto_double_checker.sv
dv/quicksort_lomuto_double_unit_tb.sv
